>>> hdl/bffa_pkg.sv
// Shared constants and types for the bitmap first-fit allocator.
package bffa_pkg;

   localparam int WORD_BITS    = 16;                       // map bits held by one cell
   localparam int BIT_IDX_W    = 4;                        // bit index inside a word
   localparam int CELL_BYTES   = 16;                       // bytes per storage cell
   localparam int CELL_SHIFT   = 4;                        // log2 of CELL_BYTES
   localparam int LEN_W        = 15;                       // byte length field
   localparam int OFF_W        = 14;                       // byte offset fields
   localparam int NEED_W       = LEN_W + 1 - CELL_SHIFT;   // cells needed, up to 2048
   localparam int GRANT_CELL_W = OFF_W - CELL_SHIFT;       // cell bits kept in the offset

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic {
      STATUS_DONE     = 1'b0,
      STATUS_NO_SPACE = 1'b1
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MARK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic marking;     // apply the run mask to the head word
      logic set_cells;   // 1 marks busy, 0 clears
   } scan_ctrl_type;

endpackage

>>> hdl/bffa_cell.sv
// One cell of the rotating map chain: holds a word of busy bits.
module bffa_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             shift_en,
   input  logic [bffa_pkg::WORD_BITS-1:0]   word_in,
   output logic [bffa_pkg::WORD_BITS-1:0]   word_out
);

   logic [bffa_pkg::WORD_BITS-1:0] word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else if (shift_en) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

>>> hdl/bffa_scan.sv
// Head unit: run search and run marking on the word leaving the chain.
module bffa_scan #(
   parameter  int CELL_COUNT = 1024,
   localparam int NW = (CELL_COUNT + bffa_pkg::WORD_BITS - 1) / bffa_pkg::WORD_BITS,
   localparam int IW = (NW > 1) ? $clog2(NW) : 1,
   localparam int CW = IW + bffa_pkg::BIT_IDX_W,
   localparam int OW = ((CW > bffa_pkg::NEED_W) ? CW : bffa_pkg::NEED_W) + 1
) (
   input  logic [bffa_pkg::WORD_BITS-1:0]  word_in,
   input  logic [IW-1:0]                   word_idx,
   input  bffa_pkg::scan_ctrl_type         ctrl,
   input  logic [bffa_pkg::NEED_W-1:0]     need,
   input  logic [bffa_pkg::NEED_W-1:0]     run_in,
   input  logic [OW-1:0]                   start,
   output logic [bffa_pkg::WORD_BITS-1:0]  word_out,
   output logic                            hit,
   output logic [OW-1:0]                   hit_start,
   output logic [bffa_pkg::NEED_W-1:0]     run_out
);

   localparam int W  = bffa_pkg::WORD_BITS;
   localparam int TW = bffa_pkg::NEED_W + 1;

   logic [OW-1:0]                    cell_idx  [W];
   logic [W-1:0]                     beyond;
   logic [W-1:0]                     busy;
   logic [W-1:0]                     seen_busy;
   logic [bffa_pkg::BIT_IDX_W-1:0]   last_busy [W];
   logic [TW-1:0]                    total     [W];
   logic [W-1:0]                     fit;
   logic [bffa_pkg::BIT_IDX_W-1:0]   hit_pos;
   logic [OW-1:0]                    run_end;
   logic [W-1:0]                     mask;

   // Global cell index of each bit; padding bits past the store count as busy.
   always_comb begin
      for (int j = 0; j < W; j++) begin
         cell_idx[j] = OW'({word_idx, bffa_pkg::BIT_IDX_W'(j)});
         beyond[j]   = (cell_idx[j] >= OW'(CELL_COUNT));
         busy[j]     = word_in[j] | beyond[j];
      end
   end

   // Free-run length ending at each bit, carried in from earlier words.
   always_comb begin
      for (int j = 0; j < W; j++) begin
         seen_busy[j] = 1'b0;
         last_busy[j] = '0;
         for (int k = 0; k <= j; k++) begin
            if (busy[k]) begin
               seen_busy[j] = 1'b1;
               last_busy[j] = bffa_pkg::BIT_IDX_W'(k);
            end
         end
         if (seen_busy[j]) begin
            total[j] = TW'(j) - TW'(last_busy[j]);
         end else begin
            total[j] = TW'(run_in) + TW'(j + 1);
         end
         fit[j] = !busy[j] && (total[j] >= TW'(need));
      end
   end

   // Lowest bit where the run first reaches the needed length.
   always_comb begin
      hit_pos = '0;
      for (int j = W - 1; j >= 0; j--) begin
         if (fit[j]) begin
            hit_pos = bffa_pkg::BIT_IDX_W'(j);
         end
      end
   end

   assign hit       = |fit;
   assign hit_start = OW'({word_idx, hit_pos}) + OW'(1) - OW'(need);
   assign run_out   = total[W-1][bffa_pkg::NEED_W-1:0];

   // Run mask for the marking pass.
   assign run_end = start + OW'(need);

   always_comb begin
      for (int j = 0; j < W; j++) begin
         mask[j] = !beyond[j] && (cell_idx[j] >= start) && (cell_idx[j] < run_end);
      end
   end

   always_comb begin
      if (!ctrl.marking) begin
         word_out = word_in;
      end else if (ctrl.set_cells) begin
         word_out = word_in | mask;
      end else begin
         word_out = word_in & ~mask;
      end
   end

endmodule

>>> hdl/bitmap_first_fit_allocator_unit.sv
// Bitmap first-fit allocator: a ring of 16-bit map cells and one scan unit.
//
// The busy map (one bit per 16-byte cell, CELL_COUNT cells) lives in a ring of
// ceil(CELL_COUNT/16) identical cells, NW in all (64 for the default). While an
// item is in work the ring rotates one word per cycle past a single head unit
// that searches or marks the word leaving cell 0 and writes it back at the tail;
// each pass is exactly one turn, so the map is aligned again at its end. An
// allocate takes a search pass, then a marking pass when a run is found; with no
// space it ends after the search. A free takes one marking pass. A zero-length
// allocate or free takes no pass. The block takes one item at a time and raises
// req_stall from accept until the result is loaded into the output register.
// A finished result may sit in that register while the next item is accepted.
// Reset clears the whole map at once. granted_offset is the start cell times 16,
// kept to 14 bits; it is 0 on a free, a zero-length allocate or no space.
module bitmap_first_fit_allocator_unit #(
   parameter int CELL_COUNT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [bffa_pkg::LEN_W-1:0]     req_byte_length,
   input  logic [bffa_pkg::OFF_W-1:0]     req_byte_offset,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bffa_pkg::OFF_W-1:0]     rsp_granted_offset,
   output logic                           rsp_status
);

   localparam int W  = bffa_pkg::WORD_BITS;
   localparam int NW = (CELL_COUNT + W - 1) / W;
   localparam int IW = (NW > 1) ? $clog2(NW) : 1;
   localparam int CW = IW + bffa_pkg::BIT_IDX_W;
   localparam int OW = ((CW > bffa_pkg::NEED_W) ? CW : bffa_pkg::NEED_W) + 1;

   bffa_pkg::state_type           state_ff, state_in;
   bffa_pkg::scan_ctrl_type       scan_ctrl;

   logic                          action_ff, action_in;
   logic [bffa_pkg::NEED_W-1:0]   need_ff, need_in;
   logic [OW-1:0]                 start_ff, start_in;
   logic [bffa_pkg::NEED_W-1:0]   run_ff, run_in;
   logic                          found_ff, found_in;
   logic [IW-1:0]                 cnt_ff, cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bffa_pkg::OFF_W-1:0]    offset_ff, offset_in;
   logic                          status_ff, status_in;

   logic                          accept;
   logic                          shift_en;
   logic                          rsp_load;
   logic                          last_word;
   logic [bffa_pkg::LEN_W:0]      len_round;
   logic [bffa_pkg::NEED_W-1:0]   req_need;

   logic [W-1:0]                  chain_word [NW];
   logic [W-1:0]                  head_new;
   logic                          hit;
   logic [OW-1:0]                 hit_start;
   logic [bffa_pkg::NEED_W-1:0]   run_out;

   // Cells needed: byte length rounded up to whole 16-byte cells.
   assign len_round = {1'b0, req_byte_length} + (bffa_pkg::LEN_W + 1)'(bffa_pkg::CELL_BYTES - 1);
   assign req_need  = len_round[bffa_pkg::LEN_W:bffa_pkg::CELL_SHIFT];

   assign accept    = req_valid && !req_stall;
   assign last_word = (cnt_ff == IW'(NW - 1));

   // ---------------------------------------------------------------- map ring
   // Cell i takes the word of cell i+1; the tail takes the head unit's output.
   for (genvar i = 0; i < NW; i++) begin : g_ring
      if (i == NW - 1) begin : g_tail
         bffa_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .word_in  (head_new),
            .word_out (chain_word[i])
         );
      end else begin : g_body
         bffa_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .word_in  (chain_word[i+1]),
            .word_out (chain_word[i])
         );
      end
   end

   bffa_scan #(
      .CELL_COUNT (CELL_COUNT)
   ) u_scan (
      .word_in   (chain_word[0]),
      .word_idx  (cnt_ff),
      .ctrl      (scan_ctrl),
      .need      (need_ff),
      .run_in    (run_ff),
      .start     (start_ff),
      .word_out  (head_new),
      .hit       (hit),
      .hit_start (hit_start),
      .run_out   (run_out)
   );

   // ---------------------------------------------------------- state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bffa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_need == '0) begin
                  state_in = bffa_pkg::ST_FINISH;
               end else if (req_action == bffa_pkg::ACT_FREE) begin
                  state_in = bffa_pkg::ST_MARK;
               end else begin
                  state_in = bffa_pkg::ST_SEARCH;
               end
            end
         end
         bffa_pkg::ST_SEARCH: begin
            if (last_word) begin
               state_in = (found_ff || hit) ? bffa_pkg::ST_MARK : bffa_pkg::ST_FINISH;
            end
         end
         bffa_pkg::ST_MARK: begin
            if (last_word) begin
               state_in = bffa_pkg::ST_FINISH;
            end
         end
         bffa_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = bffa_pkg::ST_IDLE;
            end
         end
         default: state_in = bffa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall           = 1'b1;
      shift_en            = 1'b0;
      rsp_load            = 1'b0;
      scan_ctrl.marking   = 1'b0;
      scan_ctrl.set_cells = (action_ff == bffa_pkg::ACT_ALLOC);
      unique case (state_ff)
         bffa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         bffa_pkg::ST_SEARCH: begin
            shift_en = 1'b1;
         end
         bffa_pkg::ST_MARK: begin
            shift_en          = 1'b1;
            scan_ctrl.marking = 1'b1;
         end
         bffa_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // -------------------------------------------------------------- datapath
   always_comb begin
      action_in = action_ff;
      need_in   = need_ff;
      start_in  = start_ff;
      run_in    = run_ff;
      found_in  = found_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         action_in = req_action;
         need_in   = req_need;
         start_in  = OW'(req_byte_offset[bffa_pkg::OFF_W-1:bffa_pkg::CELL_SHIFT]);
         run_in    = '0;
         found_in  = 1'b0;
         cnt_in    = '0;
      end else if (shift_en) begin
         cnt_in = last_word ? '0 : cnt_ff + IW'(1);
         // first fit only: later hits in the same pass are ignored
         if (state_ff == bffa_pkg::ST_SEARCH && !found_ff) begin
            run_in = run_out;
            if (hit) begin
               found_in = 1'b1;
               start_in = hit_start;
            end
         end
      end
   end

   // Result for the output register.
   always_comb begin
      if (action_ff == bffa_pkg::ACT_ALLOC && found_ff) begin
         offset_in = {start_ff[bffa_pkg::GRANT_CELL_W-1:0], bffa_pkg::CELL_SHIFT'(0)};
      end else begin
         offset_in = '0;
      end
      if (action_ff == bffa_pkg::ACT_ALLOC && need_ff != '0 && !found_ff) begin
         status_in = bffa_pkg::STATUS_NO_SPACE;
      end else begin
         status_in = bffa_pkg::STATUS_DONE;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bffa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      need_ff   <= need_in;
      start_ff  <= start_in;
      run_ff    <= run_in;
      if (rsp_load) begin
         offset_ff <= offset_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_offset = offset_ff;
   assign rsp_status         = status_ff;

endmodule

>>> hdl/bffa_checker.sv
// Port-level checks for the bitmap first-fit allocator, bound to the top level.
module bffa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [bffa_pkg::OFF_W-1:0]  rsp_granted_offset,
   input logic                        rsp_status
);

   // output register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted_offset)
                                 && $stable(rsp_status))
      else $error("stalled response changed");

   // one item in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // no-space result carries offset zero
   a_no_space_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bffa_pkg::STATUS_NO_SPACE |-> rsp_granted_offset == '0)
      else $error("offset on no-space result");

   // offsets fall on cell boundaries
   a_cell_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_granted_offset[bffa_pkg::CELL_SHIFT-1:0] == '0)
      else $error("granted offset not cell aligned");

endmodule

bind bitmap_first_fit_allocator_unit bffa_checker u_bffa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_granted_offset (rsp_granted_offset),
   .rsp_status         (rsp_status)
);
